### rtl/bpc_pkg.sv
// Package for the button press classifier: payload structs, command codes, register indexes.
package bpc_pkg;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int STAMP_W    = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef enum logic [1:0] {
    CMD_PIN_EVENT  = 2'd0,
    CMD_READ_CLICK = 2'd1,
    CMD_READ_LONG  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [STAMP_W-1:0] time_ms;
    logic               level_pressed;
  } in_item_t;

  typedef struct packed {
    logic flag_read;
    logic button_down;
    logic click_pending;
    logic long_pending;
  } out_item_t;

endpackage

### rtl/bpc_engine.sv
// Debounce and click / long-press state with the per-transaction update logic.
module bpc_engine import bpc_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  in_item_t              item,
  input  logic [CFG_DATA_W-1:0] debounce_ms,
  input  logic [CFG_DATA_W-1:0] long_press_ms,
  output out_item_t             res
);

  logic                  down_r, down_nxt;
  logic [TIME_WIDTH-1:0] last_change_r, last_change_nxt;
  logic [TIME_WIDTH-1:0] press_start_r, press_start_nxt;
  logic                  click_r, click_nxt;
  logic                  long_r, long_nxt;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] since;
  logic [TIME_WIDTH-1:0] held;
  logic                  flag_read;

  assign now   = TIME_WIDTH'(item.time_ms);
  assign since = now - last_change_r;
  assign held  = now - press_start_r;

  always_comb begin
    down_nxt        = down_r;
    last_change_nxt = last_change_r;
    press_start_nxt = press_start_r;
    click_nxt       = click_r;
    long_nxt        = long_r;
    flag_read       = 1'b0;
    unique case (item.command)
      CMD_PIN_EVENT: begin
        if ((since > TIME_WIDTH'(debounce_ms)) && (item.level_pressed != down_r)) begin
          down_nxt        = item.level_pressed;
          last_change_nxt = now;
          if (item.level_pressed) begin
            press_start_nxt = now;
          end else if (held >= TIME_WIDTH'(long_press_ms)) begin
            long_nxt = 1'b1;
          end else begin
            click_nxt = 1'b1;
          end
        end
      end
      CMD_READ_CLICK: begin
        flag_read = click_r;
        click_nxt = 1'b0;
      end
      CMD_READ_LONG: begin
        flag_read = long_r;
        long_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  assign res = '{flag_read:     flag_read,
                 button_down:   down_nxt,
                 click_pending: click_nxt,
                 long_pending:  long_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r        <= 1'b0;
      last_change_r <= '0;
      press_start_r <= '0;
      click_r       <= 1'b0;
      long_r        <= 1'b0;
    end else if (step) begin
      down_r        <= down_nxt;
      last_change_r <= last_change_nxt;
      press_start_r <= press_start_nxt;
      click_r       <= click_nxt;
      long_r        <= long_nxt;
    end
  end

endmodule

### rtl/button_press_classifier_top.sv
// Top level of the button press classifier: input register, engine, result register, config.
//
// Input channel in_valid/in_ready/in_data carries a command: a pin event with a
// millisecond timestamp and pressed level, or a read-and-clear of the click or
// long-press flag. Every transaction yields exactly one result on
// out_valid/out_ready/out_data: the flag read and the state after the item.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 debounce_ms,
// 1 long_press_ms) in the same edge; write only while the block is idle.
// A result passes through the input register, which loads at the accepting edge,
// and then the result register, which loads when the engine steps on that item.
// Throughput: one transaction per cycle while out_ready stays high; the state
// update in the engine, done at each step, sets that figure.
// When the receiver stalls, the result register holds, one more item waits in
// the input register, and in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) empties both registers, sets the button to
// released, clears both flags and time stamps, and loads debounce 50 ms and
// long press 1000 ms.
module button_press_classifier_top import bpc_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                  in_valid_r, in_valid_nxt;
  in_item_t              in_data_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r;
  logic [CFG_DATA_W-1:0] debounce_r;
  logic [CFG_DATA_W-1:0] long_press_r;
  logic                  step;
  out_item_t             res;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  assign in_valid_nxt  = (in_valid && in_ready) || (in_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        REG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpc_engine #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (in_data_r),
    .debounce_ms  (debounce_r),
    .long_press_ms(long_press_r),
    .res          (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input register empty but not ready");

  a_event_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    step && (in_data_r.command == CMD_PIN_EVENT) |=> !out_data_r.flag_read)
    else $error("pin event returned a flag");

  a_click_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step && (in_data_r.command == CMD_READ_CLICK) |=> !out_data_r.click_pending)
    else $error("click flag not cleared by read");

  a_long_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step && (in_data_r.command == CMD_READ_LONG) |=> !out_data_r.long_pending)
    else $error("long-press flag not cleared by read");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed transaction produced no result");

endmodule
